>>> rtl/rsk_pkg.sv
// rsk_pkg: shared types for the record sort-by-key block
// key, tag and record types, compare-exchange result
// no dependencies
package rsk_pkg;

  localparam int unsigned KeyWidth = 32;
  localparam int unsigned TagWidth = 16;

  typedef logic signed [KeyWidth-1:0] key_t;
  typedef logic        [TagWidth-1:0] tag_t;

  // one stored record
  typedef struct packed {
    key_t key;
    tag_t tag;
  } rec_t;

  // result of one compare-exchange step
  typedef struct packed {
    rec_t lo;
    rec_t hi;
  } cmpx_t;

endpackage : rsk_pkg

>>> rtl/rsk_if.sv
// rsk_if: valid/ready channel interfaces for records in and sorted records out
// depends on rsk_pkg for the field types
interface rsk_in_if;
  logic            valid;
  logic            ready;
  rsk_pkg::key_t   record_key;
  rsk_pkg::tag_t   record_tag;
  logic            is_last;

  modport source (output valid, record_key, record_tag, is_last, input ready);
  modport sink   (input valid, record_key, record_tag, is_last, output ready);
endinterface : rsk_in_if

interface rsk_out_if;
  logic            valid;
  logic            ready;
  rsk_pkg::key_t   sorted_key;
  rsk_pkg::tag_t   sorted_tag;
  logic            final_flag;
  logic            overflow;

  modport source (output valid, sorted_key, sorted_tag, final_flag, overflow, input ready);
  modport sink   (input valid, sorted_key, sorted_tag, final_flag, overflow, output ready);
endinterface : rsk_out_if

>>> rtl/rsk_store.sv
// rsk_store: record memory, one write port and one registered read port
// depends on rsk_pkg for the record type
module rsk_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  rsk_pkg::rec_t    wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output rsk_pkg::rec_t    rdata_o
);
  import rsk_pkg::*;

  rec_t mem_q [Depth];
  rec_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : rsk_store

>>> rtl/rsk_cmpx.sv
// rsk_cmpx: shared compare-exchange unit, signed key compare
// depends on rsk_pkg for the record and result types
module rsk_cmpx (
  input  rsk_pkg::rec_t  a_i,
  input  rsk_pkg::rec_t  b_i,
  output rsk_pkg::cmpx_t res_o
);
  import rsk_pkg::*;

  logic gt;

  // strict compare keeps equal keys in arrival order
  assign gt = $signed(a_i.key) > $signed(b_i.key);

  always_comb begin
    res_o.lo   = gt ? b_i : a_i;
    res_o.hi   = gt ? a_i : b_i;
  end

endmodule : rsk_cmpx

>>> rtl/record_sort_by_key_core.sv
// record_sort_by_key_core: collects records, sorts them by key, emits them
// depends on rsk_pkg, rsk_if, rsk_store and rsk_cmpx
//
//  channel  dir  fields                                           transfer when
//  rec_i    in   record_key, record_tag, is_last                  valid && ready
//  srt_o    out  sorted_key, sorted_tag, final_flag, overflow     valid && ready
//
// loading takes one record per cycle while the block is idle
// sorting runs n-1 passes through the memory for n stored records, one
// compare-exchange per cycle on its single read port
// each sorted record is then read, registered and held until taken
// reset is asynchronous, active low, and empties the store; no clearing pass
// rec_i.ready is low from the last record of a set until its final transfer out
module record_sort_by_key_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rsk_in_if.sink        rec_i,
  rsk_out_if.source     srt_o
);
  import rsk_pkg::*;

  localparam int unsigned AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountW = $clog2(DEPTH + 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_PRIME  = 8'b0000_0010,
    ST_HOLD   = 8'b0000_0100,
    ST_STEP   = 8'b0000_1000,
    ST_FLUSH  = 8'b0001_0000,
    ST_EMIT_RD = 8'b0010_0000,
    ST_EMIT_LD = 8'b0100_0000,
    ST_EMIT_OUT = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                dropped_q, dropped_d;
  logic [AddrW-1:0]    lim_q, lim_d;
  logic [AddrW-1:0]    pos_q, pos_d;
  logic [AddrW-1:0]    idx_q, idx_d;
  rec_t                hold_q, hold_d;
  rec_t                out_rec_q, out_rec_d;
  logic                out_final_q, out_final_d;
  logic                out_ovf_q, out_ovf_d;

  logic                in_xfer, out_xfer, has_room;
  logic                st_we;
  logic [AddrW-1:0]    st_waddr, st_raddr, last_idx;
  rec_t                st_wdata, st_rdata, in_rec;
  cmpx_t               cx;

  assign in_xfer  = rec_i.valid && rec_i.ready;
  assign out_xfer = srt_o.valid && srt_o.ready;
  assign has_room = count_q < CountW'(DEPTH);
  assign last_idx = AddrW'(count_q - CountW'(1));
  assign in_rec   = '{key: rec_i.record_key, tag: rec_i.record_tag};

  // record memory
  rsk_store #(
    .Depth (DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // compare-exchange between the bubbling record and the one just read
  rsk_cmpx u_cmpx (
    .a_i   (hold_q),
    .b_i   (st_rdata),
    .res_o (cx)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    lim_d       = lim_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    hold_d      = hold_q;
    out_rec_d   = out_rec_q;
    out_final_d = out_final_q;
    out_ovf_d   = out_ovf_q;
    st_we       = 1'b0;
    st_waddr    = AddrW'(count_q);
    st_wdata    = in_rec;
    st_raddr    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (has_room) begin
            st_we   = 1'b1;
            count_d = count_q + CountW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (rec_i.is_last) begin
            lim_d = AddrW'(count_d - CountW'(1));
            idx_d = '0;
            // fewer than two records need no sort
            state_d = (count_d < CountW'(2)) ? ST_EMIT_RD : ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        st_raddr = '0;
        state_d  = ST_HOLD;
      end
      ST_HOLD: begin
        hold_d   = st_rdata;
        st_raddr = AddrW'(1);
        pos_d    = AddrW'(1);
        state_d  = ST_STEP;
      end
      ST_STEP: begin
        // smaller record settles one place back, larger keeps bubbling
        st_we    = 1'b1;
        st_waddr = pos_q - AddrW'(1);
        st_wdata = cx.lo;
        hold_d   = cx.hi;
        st_raddr = pos_q + AddrW'(1);
        if (pos_q == lim_q) begin
          state_d = ST_FLUSH;
        end else begin
          pos_d = pos_q + AddrW'(1);
        end
      end
      ST_FLUSH: begin
        // largest of this pass lands at the end of the unsorted part
        st_we    = 1'b1;
        st_waddr = lim_q;
        st_wdata = hold_q;
        if (lim_q == AddrW'(1)) begin
          state_d = ST_EMIT_RD;
        end else begin
          lim_d   = lim_q - AddrW'(1);
          state_d = ST_PRIME;
        end
      end
      ST_EMIT_RD: begin
        st_raddr = idx_q;
        state_d  = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_rec_d   = st_rdata;
        out_final_d = (idx_q == last_idx);
        out_ovf_d   = dropped_q;
        state_d     = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_xfer) begin
          if (out_final_q) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = ST_IDLE;
          end else begin
            idx_d   = idx_q + AddrW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    lim_q       <= lim_d;
    pos_q       <= pos_d;
    idx_q       <= idx_d;
    hold_q      <= hold_d;
    out_rec_q   <= out_rec_d;
    out_final_q <= out_final_d;
    out_ovf_q   <= out_ovf_d;
  end

  // channel outputs
  assign rec_i.ready      = (state_q == ST_IDLE);
  assign srt_o.valid      = (state_q == ST_EMIT_OUT);
  assign srt_o.sorted_key = out_rec_q.key;
  assign srt_o.sorted_tag = out_rec_q.tag;
  assign srt_o.final_flag = out_final_q;
  assign srt_o.overflow   = out_ovf_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(DEPTH))
    else $error("record count above store depth");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rec_i.ready && srt_o.valid))
    else $error("input ready while a result is offered");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (pos_q <= lim_q && lim_q <= last_idx))
    else $error("sort step outside the unsorted part");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && srt_o.final_flag) |=> (state_q == ST_IDLE && count_q == '0 && !dropped_q))
    else $error("store not emptied after final transfer");

  a_nonfinal_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !srt_o.final_flag) |=> (state_q == ST_EMIT_RD && count_q != '0))
    else $error("run ended before final result");

endmodule : record_sort_by_key_core
